// ===== rtl/bsdf_pkg.sv =====
`default_nettype none

package bsdf_pkg;

    localparam int NUM_AXES   = 3;
    localparam int NUM_FIELDS = 3 * NUM_AXES;

    // Density output, unsigned Q1.15
    localparam int DENS_BITS = 16;
    localparam logic [DENS_BITS-1:0] HALF_Q15 = 16'd16384;
    localparam logic [DENS_BITS-1:0] ONE_Q15  = 16'd32768;

    // Inside-branch density never exceeds one half, so it fits 15 bits
    localparam int IN_DENS_BITS = 15;

    // sdf * 2^14 = dist2 * 2^(13 - FRAC_BITS), dist2 measured at twice the scale
    localparam int SDF_SHIFT = 13;

    // Square root operand: floor(S * 2^(26 - 2F)) stays below 3 * 2^28
    localparam int ROOT_PRE_SHIFT = 2 * SDF_SHIFT;
    localparam int ROOT_IN_BITS   = 30;
    localparam int ROOT_BITS      = 15;

    typedef struct packed {
        logic                    far_out;
        logic                    outside;
        logic [IN_DENS_BITS-1:0] in_dens;
    } meta_t;

endpackage

`default_nettype wire

// ===== rtl/box_sdf_density_core.sv =====
// Box signed-distance density core.
// Stages from an accepted input word to the result word on m_axis
// (4 front stages, 1 square-root operand stage, 15 square-root stages, output register).
// One word per cycle while the skid is empty; 15-stage bit-per-stage root sets depth.
// Reset: synchronous, active low; clears every valid bit, output and skid flags included.
`default_nettype none

module box_sdf_density_core #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata, low bit up: point_x, point_y, point_z, min_corner_x, min_corner_y,
    // min_corner_z, max_corner_x, max_corner_y, max_corner_z (COORD_BITS each),
    // zero fill to a whole byte
    input  wire logic [((bsdf_pkg::NUM_FIELDS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata, low bit up: density (unsigned Q1.15)
    output logic [bsdf_pkg::DENS_BITS-1:0] m_axis_tdata
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = CW + 2;              // 2p - min - max
    localparam int HW   = CW + 1;              // max - min, and |a|
    localparam int QW   = CW + 3;              // q at twice the scale
    localparam int PW   = FRAC_BITS + 1;       // positive q below 2^(F+1)
    localparam int SQW  = 2 * PW;
    localparam int SW   = 2 * FRAC_BITS + 4;   // sum of three squares
    localparam int XW   = SW + bsdf_pkg::ROOT_PRE_SHIFT;
    localparam int FW   = FRAC_BITS + 15;
    localparam int TW   = bsdf_pkg::ROOT_IN_BITS;
    localparam int RW   = bsdf_pkg::ROOT_BITS;
    localparam int IDW  = bsdf_pkg::IN_DENS_BITS;
    localparam int DW   = bsdf_pkg::DENS_BITS;
    localparam int NAX  = bsdf_pkg::NUM_AXES;

    // Whole pipeline advances unless the skid register holds a word.
    logic en;
    logic push;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic [DW-1:0] skid_data_reg, skid_data_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: a = 2p - min - max, h = max - min per axis
    // ------------------------------------------------------------------
    logic signed [CW-1:0] in_p  [NAX];
    logic signed [CW-1:0] in_lo [NAX];
    logic signed [CW-1:0] in_hi [NAX];

    logic                 v1_reg;
    logic signed [AW-1:0] a_reg  [NAX];
    logic signed [AW-1:0] a_next [NAX];
    logic signed [HW-1:0] h_reg  [NAX];
    logic signed [HW-1:0] h_next [NAX];

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            in_p[i]   = $signed(s_axis_tdata[i*CW +: CW]);
            in_lo[i]  = $signed(s_axis_tdata[(NAX+i)*CW +: CW]);
            in_hi[i]  = $signed(s_axis_tdata[(2*NAX+i)*CW +: CW]);
            a_next[i] = (AW'(in_p[i]) <<< 1) - AW'(in_lo[i]) - AW'(in_hi[i]);
            h_next[i] = HW'(in_hi[i]) - HW'(in_lo[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: q = |a| - h
    // ------------------------------------------------------------------
    logic                 v2_reg;
    logic signed [AW-1:0] a_neg [NAX];
    logic        [HW-1:0] a_abs [NAX];
    logic signed [QW-1:0] q_reg  [NAX];
    logic signed [QW-1:0] q_next [NAX];

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            a_neg[i]  = a_reg[i][AW-1] ? -a_reg[i] : a_reg[i];
            a_abs[i]  = a_neg[i][HW-1:0];
            q_next[i] = $signed(QW'(a_abs[i])) - QW'(h_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: classify, clip positive parts, take the largest q
    // ------------------------------------------------------------------
    logic                 v3_reg;
    logic                 pos [NAX];
    logic                 big [NAX];
    logic signed [QW-1:0] m01;
    logic                 far3_reg, far3_next;
    logic                 out3_reg, out3_next;
    logic        [PW-1:0] pq_reg  [NAX];
    logic        [PW-1:0] pq_next [NAX];
    logic signed [QW-1:0] m_reg, m_next;

    always_comb begin
        far3_next = 1'b0;
        out3_next = 1'b0;
        for (int i = 0; i < NAX; i++) begin
            pos[i]     = !q_reg[i][QW-1] && (q_reg[i] != '0);
            big[i]     = pos[i] && (|q_reg[i][QW-2:PW]);
            pq_next[i] = pos[i] ? q_reg[i][PW-1:0] : '0;
            far3_next  = far3_next | big[i];
            out3_next  = out3_next | pos[i];
        end
        m01    = (q_reg[1] > q_reg[0]) ? q_reg[1] : q_reg[0];
        m_next = (q_reg[2] > m01) ? q_reg[2] : m01;
    end

    // ------------------------------------------------------------------
    // Stage 4: square positive parts; magnitude of the inside distance
    // ------------------------------------------------------------------
    logic                 v4_reg;
    logic                 far4_reg, out4_reg;
    logic       [SQW-1:0] sq_reg  [NAX];
    logic       [SQW-1:0] sq_next [NAX];
    logic        [QW-1:0] mag_w;
    logic                 mag_big_reg, mag_big_next;
    logic        [PW-1:0] mag_n_reg, mag_n_next;

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            sq_next[i] = SQW'(pq_reg[i]) * SQW'(pq_reg[i]);
        end
        mag_w        = -m_reg;
        mag_big_next = |mag_w[QW-1:PW];
        mag_n_next   = mag_w[PW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 5: root operand and inside density; feeds the root pipeline
    // ------------------------------------------------------------------
    logic [SW-1:0]    s_sum;
    logic [XW-1:0]    x_wide;
    logic [FW-1:0]    scaled_w;
    logic [IDW-1:0]   in_dens_w;
    bsdf_pkg::meta_t  meta5;

    always_comb begin
        s_sum     = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        x_wide    = {s_sum, {bsdf_pkg::ROOT_PRE_SHIFT{1'b0}}} >> (2 * FRAC_BITS);
        // ceiling of mag * 2^(13-F); exact shift when F is 13 or less
        scaled_w  = ((FW'(mag_n_reg) << bsdf_pkg::SDF_SHIFT) + FW'((1 << FRAC_BITS) - 1))
                    >> FRAC_BITS;
        in_dens_w = mag_big_reg ? '0
                  : IDW'(bsdf_pkg::HALF_Q15) - scaled_w[IDW-1:0];
        meta5.far_out = far4_reg;
        meta5.outside = out4_reg;
        meta5.in_dens = in_dens_w;
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, remainder kept as T - root^2
    // ------------------------------------------------------------------
    logic            sq_v_reg    [0:RW];
    logic [TW-1:0]   sq_rem_reg  [0:RW];
    logic [RW-1:0]   sq_root_reg [0:RW];
    bsdf_pkg::meta_t sq_meta_reg [0:RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_axis_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            sq_v_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg          <= a_next;
            h_reg          <= h_next;
            q_reg          <= q_next;
            far3_reg       <= far3_next;
            out3_reg       <= out3_next;
            pq_reg         <= pq_next;
            m_reg          <= m_next;
            far4_reg       <= far3_reg;
            out4_reg       <= out3_reg;
            sq_reg         <= sq_next;
            mag_big_reg    <= mag_big_next;
            mag_n_reg      <= mag_n_next;
            sq_rem_reg[0]  <= x_wide[TW-1:0];
            sq_root_reg[0] <= '0;
            sq_meta_reg[0] <= meta5;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_root
        localparam int J = RW - 1 - k;

        logic [TW:0]   trial;
        logic          take;
        logic [TW-1:0] rem_next;
        logic [RW-1:0] root_next;

        always_comb begin
            trial     = ((TW+1)'(sq_root_reg[k]) << (J + 1)) + ((TW+1)'(1) << (2 * J));
            take      = {1'b0, sq_rem_reg[k]} >= trial;
            rem_next  = take ? sq_rem_reg[k] - trial[TW-1:0] : sq_rem_reg[k];
            root_next = take ? (sq_root_reg[k] | (RW'(1) << J)) : sq_root_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= root_next;
                sq_meta_reg[k+1] <= sq_meta_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final select: far outside saturates, outside adds the root, inside
    // uses the precomputed density; outside clamps at one
    // ------------------------------------------------------------------
    logic [RW-1:0]   root_fin;
    bsdf_pkg::meta_t meta_fin;
    logic [DW-1:0]   pipe_dens;

    always_comb begin
        root_fin = sq_root_reg[RW];
        meta_fin = sq_meta_reg[RW];
        if (meta_fin.far_out) begin
            pipe_dens = bsdf_pkg::ONE_Q15;
        end else if (meta_fin.outside) begin
            pipe_dens = root_fin[RW-1] ? bsdf_pkg::ONE_Q15
                      : bsdf_pkg::HALF_Q15 + DW'(root_fin);
        end else begin
            pipe_dens = DW'(meta_fin.in_dens);
        end
    end

    assign push = en && sq_v_reg[RW];

    // ------------------------------------------------------------------
    // Output register plus skid register: a word arriving while the
    // output is stalled parks in the skid register and stops the pipe.
    // ------------------------------------------------------------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = pipe_dens;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_dens;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bsdf_chk.sv =====
`default_nettype none

module bsdf_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [bsdf_pkg::DENS_BITS-1:0] m_axis_tdata
);

    // density is saturated to one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata <= bsdf_pkg::ONE_Q15))
        else $error("density above one");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word dropped or changed under stall");

    // input side stops only after the output side has stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // no result word right after reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result word right after reset");

endmodule

bind box_sdf_density_core bsdf_chk u_bsdf_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
